>>> hw/rtl/c128a_pkg.sv
// Shared constants, types and helpers for the Code 128 set A encoder.
package c128a_pkg;

	localparam int unsigned SymW = 7;
	localparam int unsigned ProdW = 13;
	localparam int unsigned NumSym = 107;
	localparam logic [SymW-1:0] SYM_START_A = 7'd103;
	localparam logic [SymW-1:0] SYM_STOP = 7'd106;
	localparam logic [SymW-1:0] CHECK_MOD = 7'd103;
	localparam logic [SymW-1:0] WEIGHT_MAX = 7'd102;

	localparam logic [0:0] CMD_CHAR = 1'b0;
	localparam logic [0:0] CMD_END = 1'b1;

	// Six element widths packed as octal digits, first bar in the top digit.
	localparam logic [17:0] PATTERN [NumSym] = '{
		18'o212222, 18'o222122, 18'o222221, 18'o121223, 18'o121322, 18'o131222, 18'o122213,
		18'o122312, 18'o132212, 18'o221213, 18'o221312, 18'o231212, 18'o112232, 18'o122132,
		18'o122231, 18'o113222, 18'o123122, 18'o123221, 18'o223211, 18'o221132, 18'o221231,
		18'o213212, 18'o223112, 18'o312131, 18'o311222, 18'o321122, 18'o321221, 18'o312212,
		18'o322112, 18'o322211, 18'o212123, 18'o212321, 18'o232121, 18'o111323, 18'o131123,
		18'o131321, 18'o112313, 18'o132113, 18'o132311, 18'o211313, 18'o231113, 18'o231311,
		18'o112133, 18'o112331, 18'o132131, 18'o113123, 18'o113321, 18'o133121, 18'o313121,
		18'o211331, 18'o231131, 18'o213113, 18'o213311, 18'o213131, 18'o311123, 18'o311321,
		18'o331121, 18'o312113, 18'o312311, 18'o332111, 18'o314111, 18'o221411, 18'o431111,
		18'o111224, 18'o111422, 18'o121124, 18'o121421, 18'o141122, 18'o141221, 18'o112214,
		18'o112412, 18'o122114, 18'o122411, 18'o142112, 18'o142211, 18'o241211, 18'o221114,
		18'o413111, 18'o241112, 18'o134111, 18'o111242, 18'o121142, 18'o121241, 18'o114212,
		18'o124112, 18'o124211, 18'o411212, 18'o421112, 18'o421211, 18'o212141, 18'o214121,
		18'o412121, 18'o111143, 18'o111341, 18'o131141, 18'o114113, 18'o114311, 18'o411113,
		18'o411311, 18'o113141, 18'o114131, 18'o311141, 18'o411131, 18'o211412, 18'o211214,
		18'o211232, 18'o233111
	};

	typedef struct packed {
		logic add;
		logic clr;
	} chk_ctl_t;

	// Reduce a value below 103 * 128 by restoring subtraction.
	function automatic logic [SymW-1:0] mod103(input logic [ProdW:0] x);
		logic [ProdW:0] r;
		logic [ProdW:0] d;
		r = x;
		for (int k = 6; k >= 0; k--) begin
			d = (ProdW+1)'({7'd0, CHECK_MOD} << k);
			if (r >= d) begin
				r = r - d;
			end
		end
		return r[SymW-1:0];
	endfunction

endpackage

>>> hw/rtl/c128a_check.sv
// Running Code 128 checksum, kept mod 103.
module c128a_check (
	input  logic                           clk,
	input  logic                           arst_n,
	input  c128a_pkg::chk_ctl_t            ctl,
	input  logic [c128a_pkg::ProdW-1:0]    prod,
	output logic [c128a_pkg::SymW-1:0]     check
);
	import c128a_pkg::*;

	logic [SymW-1:0] check_q;
	logic [ProdW:0]  sum;

	assign sum = (ProdW+1)'(check_q) + (ProdW+1)'(prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_q <= '0;
		end else if (ctl.clr) begin
			check_q <= '0;
		end else if (ctl.add) begin
			check_q <= mod103(sum);
		end
	end

	assign check = check_q;

endmodule

>>> hw/rtl/code128a_barcode_encoder.sv
// Code 128 set A encoder top level: character stream in, symbols with widths out.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------------
//  in      | in_valid, in_stall  | command, character
//  out     | out_valid, out_stall| symbol, width_1..width_7, last_of_run
//
// A request that opens a message or ends one, or encodes a printable character,
// goes to one stage register and then gives 1 to 3 results, one per cycle while the
// output is not stalled, through the output register. The sequencing of results
// out of the stage register sets the cases with more than one result. Unprintable
// characters are taken and dropped at once. Reset clears message state and the checksum.
// A stalled output holds its result and backs the stage up to in_stall.
module code128a_barcode_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       command,
	input  logic [7:0] character,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] symbol,
	output logic [2:0] width_1,
	output logic [2:0] width_2,
	output logic [2:0] width_3,
	output logic [2:0] width_4,
	output logic [2:0] width_5,
	output logic [2:0] width_6,
	output logic [1:0] width_7,
	output logic       last_of_run
);
	import c128a_pkg::*;

	logic            open_q;
	logic [SymW-1:0] weight_q;

	logic             valid_s1;
	logic             cmd_s1;
	logic [5:0]       v_s1;
	logic [ProdW-1:0] prod_s1;
	logic             start_s1;
	logic [1:0]       idx_s1;

	logic            out_valid_q;
	logic [SymW-1:0] symbol_q;
	logic [17:0]     pat_q;
	logic            last_q;

	logic            printable;
	logic [7:0]      diff;
	logic [5:0]      v_in;
	logic            live;
	logic            accept;
	logic            load;
	logic [SymW-1:0] w_used;
	logic [SymW-1:0] w_next;
	logic [1:0]      last_idx;
	logic [1:0]      k;
	logic            out_free;
	logic            emit;
	logic            s1_done;
	logic [SymW-1:0] sym_sel;
	logic [SymW-1:0] check;
	chk_ctl_t        chk_ctl;

	assign printable = (character >= 8'd32) && (character <= 8'd95);
	assign diff      = character - 8'd32;
	assign v_in      = diff[5:0];
	assign live      = (command == CMD_END) || printable;

	assign out_free = !out_valid_q || !out_stall;
	assign emit     = valid_s1 && out_free;
	assign last_idx = {1'b0, start_s1} + ((cmd_s1 == CMD_END) ? 2'd1 : 2'd0);
	assign s1_done  = emit && (idx_s1 == last_idx);

	assign in_stall = valid_s1 && !s1_done;
	assign accept   = in_valid && !in_stall;
	assign load     = accept && live;

	// Opening a message restarts the weight at one.
	assign w_used = open_q ? weight_q : 7'd1;
	assign w_next = (w_used == WEIGHT_MAX) ? '0 : w_used + 7'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= 1'b0;
			weight_q <= '0;
		end else if (load) begin
			if (command == CMD_END) begin
				open_q   <= 1'b0;
				weight_q <= '0;
			end else begin
				open_q   <= 1'b1;
				weight_q <= w_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
		end else if (load) begin
			valid_s1 <= 1'b1;
			idx_s1   <= '0;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end else if (emit) begin
			idx_s1 <= idx_s1 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_s1   <= command;
			v_s1     <= v_in;
			prod_s1  <= ProdW'(v_in) * ProdW'(w_used);
			start_s1 <= !open_q;
		end
	end

	// Fold a finished character into the checksum as it leaves the stage; a finished end clears it.
	assign chk_ctl.add = s1_done && (cmd_s1 == CMD_CHAR);
	assign chk_ctl.clr = s1_done && (cmd_s1 == CMD_END);

	c128a_check u_check (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (chk_ctl),
		.prod   (prod_s1),
		.check  (check)
	);

	assign k = idx_s1 - {1'b0, start_s1};

	always_comb begin
		if (start_s1 && (idx_s1 == 2'd0)) begin
			sym_sel = SYM_START_A;
		end else if (cmd_s1 == CMD_CHAR) begin
			sym_sel = SymW'(v_s1);
		end else if (k == 2'd0) begin
			sym_sel = check;
		end else begin
			sym_sel = SYM_STOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			symbol_q <= sym_sel;
			pat_q    <= PATTERN[sym_sel];
			last_q   <= (idx_s1 == last_idx);
		end
	end

	assign out_valid   = out_valid_q;
	assign symbol      = symbol_q;
	assign width_1     = pat_q[17:15];
	assign width_2     = pat_q[14:12];
	assign width_3     = pat_q[11:9];
	assign width_4     = pat_q[8:6];
	assign width_5     = pat_q[5:3];
	assign width_6     = pat_q[2:0];
	assign width_7     = (symbol_q == SYM_STOP) ? 2'd2 : 2'd0;
	assign last_of_run = last_q;

endmodule

>>> hw/rtl/c128a_checker.sv
// Port-level checks for the Code 128 set A encoder, bound to the top level.
module c128a_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [6:0] symbol,
	input logic [1:0] width_7,
	input logic       last_of_run
);
	import c128a_pkg::*;

	// Hold a stalled request until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("stalled request dropped");

	// Hold a stalled result.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(symbol) && $stable(last_of_run))
		else $error("stalled result changed");

	// Stop always closes the run and carries the terminating bar.
	a_stop_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (symbol == SYM_STOP) |-> last_of_run && (width_7 == 2'd2))
		else $error("stop symbol malformed");

	a_no_term_bar: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (symbol != SYM_STOP) |-> (width_7 == 2'd0))
		else $error("terminating bar on non-stop symbol");

	// Start is always followed by another symbol of the same request.
	a_start_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (symbol == SYM_START_A) |-> !last_of_run)
		else $error("start symbol ends a run");

endmodule

bind code128a_barcode_encoder c128a_checker u_c128a_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.symbol      (symbol),
	.width_7     (width_7),
	.last_of_run (last_of_run)
);
